### rtl/core/mck_pkg.sv
package mck_pkg;

    localparam int UNIT_W = 16;
    localparam int CD_W   = 20;
    localparam int PAT_W  = 5;
    localparam int CNT_W  = 3;
    localparam int CHAR_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [UNIT_W-1:0] RESET_UNIT = 16'd200;

    localparam logic [0:0] REG_UNIT_TICKS = 1'b0;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [CNT_W-1:0] left;
        t_phase           phase;
        logic [CD_W-1:0]  countdown;
    } t_state;

    // lamp_on in bit 0, busy_res in bit 1, dropped in bit 2
    typedef struct packed {
        logic dropped;
        logic busy;
        logic lamp;
    } t_result;

    // code: bits 7..3 pattern (first element in bit 3, 1 = dash), bits 2..0 count
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h12;
            5'd1:    c = 8'h0C;
            5'd2:    c = 8'h2C;
            5'd3:    c = 8'h0B;
            5'd4:    c = 8'h01;
            5'd5:    c = 8'h24;
            5'd6:    c = 8'h1B;
            5'd7:    c = 8'h04;
            5'd8:    c = 8'h02;
            5'd9:    c = 8'h74;
            5'd10:   c = 8'h2B;
            5'd11:   c = 8'h14;
            5'd12:   c = 8'h1A;
            5'd13:   c = 8'h0A;
            5'd14:   c = 8'h3B;
            5'd15:   c = 8'h34;
            5'd16:   c = 8'h5C;
            5'd17:   c = 8'h13;
            5'd18:   c = 8'h03;
            5'd19:   c = 8'h09;
            5'd20:   c = 8'h23;
            5'd21:   c = 8'h44;
            5'd22:   c = 8'h33;
            5'd23:   c = 8'h4C;
            5'd24:   c = 8'h6C;
            5'd25:   c = 8'h1C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_code(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'hFD;
            4'd1:    c = 8'hF5;
            4'd2:    c = 8'hE5;
            4'd3:    c = 8'hC5;
            4'd4:    c = 8'h85;
            4'd5:    c = 8'h05;
            4'd6:    c = 8'h0D;
            4'd7:    c = 8'h1D;
            4'd8:    c = 8'h3D;
            4'd9:    c = 8'h7D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/mck_step.sv
module mck_step (
    input  mck_pkg::t_state              i_state,
    input  logic                         i_cmd,
    input  logic [mck_pkg::CHAR_W-1:0]   i_char,
    input  logic [mck_pkg::UNIT_W-1:0]   i_unit,
    output mck_pkg::t_state              o_state,
    output mck_pkg::t_result             o_result
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] unit_len;
    logic [CD_W-1:0]   u20;
    logic [CD_W-1:0]   dash20;
    logic [CD_W-1:0]   gap3;
    logic [CD_W-1:0]   gap9;
    logic [CHAR_W-1:0] ch_up;
    logic              is_letter;
    logic              is_digit;
    logic [CHAR_W-1:0] l_off;
    logic [CHAR_W-1:0] d_off;
    logic [7:0]        code;
    logic [CD_W-1:0]   cd_dec;
    logic              drop;

    assign unit_len = (i_unit == '0) ? UNIT_W'(1) : i_unit;
    assign u20      = CD_W'(unit_len);
    assign dash20   = (u20 << 1) + u20;
    assign gap3     = (u20 << 1) + u20;
    assign gap9     = (u20 << 3) + u20;

    assign ch_up     = (i_char >= CH_LOWER_A && i_char <= CH_LOWER_Z) ? i_char - CASE_DIFF
                                                                      : i_char;
    assign is_letter = (ch_up >= CH_UPPER_A) && (ch_up <= CH_UPPER_Z);
    assign is_digit  = (ch_up >= CH_ZERO) && (ch_up <= CH_NINE);
    assign l_off     = ch_up - CH_UPPER_A;
    assign d_off     = ch_up - CH_ZERO;
    assign code      = is_letter ? letter_code(l_off[4:0]) : digit_code(d_off[3:0]);
    assign cd_dec    = (i_state.countdown != '0) ? i_state.countdown - CD_W'(1) : '0;

    always_comb begin
        o_state = i_state;
        drop    = 1'b0;
        if (i_cmd == CMD_LOAD) begin
            if (i_state.phase != PH_IDLE) begin
                drop = 1'b1;
            end else if (is_letter || is_digit) begin
                o_state.countdown = code[3] ? dash20 : u20;
                o_state.pattern   = {1'b0, code[7:4]};
                o_state.left      = code[2:0] - CNT_W'(1);
                o_state.phase     = PH_ON;
            end else if (ch_up == CH_SPACE) begin
                o_state.countdown = gap9;
                o_state.phase     = PH_GAP;
            end else begin
                o_state.countdown = gap3;
                o_state.phase     = PH_GAP;
            end
        end else if (i_state.phase != PH_IDLE) begin
            o_state.countdown = cd_dec;
            if (cd_dec == '0) begin
                case (i_state.phase)
                    PH_ON: begin
                        o_state.countdown = u20;
                        o_state.phase     = PH_OFF;
                    end
                    PH_OFF: begin
                        if (i_state.left != '0) begin
                            o_state.countdown = i_state.pattern[0] ? dash20 : u20;
                            o_state.pattern   = i_state.pattern >> 1;
                            o_state.left      = i_state.left - CNT_W'(1);
                            o_state.phase     = PH_ON;
                        end else begin
                            o_state.countdown = gap3;
                            o_state.phase     = PH_GAP;
                        end
                    end
                    PH_GAP: begin
                        o_state.phase = PH_IDLE;
                    end
                    default: begin
                        o_state.phase = PH_IDLE;
                    end
                endcase
            end
        end
        o_result.lamp    = (o_state.phase == PH_ON);
        o_result.busy    = (o_state.phase != PH_IDLE);
        o_result.dropped = drop;
    end

endmodule

### rtl/core/morse_code_keyer.sv
// The result of an accepted request is registered and shows on m_axis in the next cycle.
// Throughput: one request per cycle; s_axis_tready drops only while the output
// register holds a result that m_axis_tready has not taken.
// Reset (synchronous, active low): keyer idle, output empty, unit_ticks = 200.
module morse_code_keyer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
    input  logic                         s_axis_tuser,   // [0] cmd
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [0] lamp_on [1] busy_res [2] dropped
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mck_pkg::APB_AW-1:0]   paddr,
    input  logic [mck_pkg::APB_DW-1:0]   pwdata,
    output logic [mck_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mck_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_result           r_out;
    t_result           n_out;
    logic              r_out_valid;
    logic [UNIT_W-1:0] r_unit;
    logic              s_acc;
    logic              cfg_wr;

    assign pready        = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready
                           && (paddr[APB_AW-1 -: 1] == REG_UNIT_TICKS) && (paddr[1:0] == 2'b00);
    assign prdata        = (paddr[APB_AW-1 -: 1] == REG_UNIT_TICKS) ? APB_DW'(r_unit) : '0;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out};

    mck_step u_step (
        .i_state  (r_state),
        .i_cmd    (s_axis_tuser),
        .i_char   (s_axis_tdata),
        .i_unit   (r_unit),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{pattern: '0, left: '0, phase: PH_IDLE, countdown: '0};
            r_out_valid <= 1'b0;
            r_unit      <= RESET_UNIT;
        end else begin
            if (cfg_wr) begin
                r_unit <= pwdata[UNIT_W-1:0];
            end
            if (s_acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/core/mck_checker.sv
module mck_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [7:0]                   m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_lamp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("lamp on while not busy");

    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("drop flagged while idle");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no result");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (.*);
